@@ hw/rtl/lsp_pkg.sv @@
`default_nettype none
package lsp_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int IDX_W      = 12;
    localparam int MAX_IDX_I  = (MAX_POINTS - 1 > 4095) ? 4095 : MAX_POINTS - 1;
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_IDX_I);

    // Register indexes on the configuration port
    localparam logic [2:0] REG_START_ANGLE   = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP    = 3'd1;
    localparam logic [2:0] REG_MIN_RANGE     = 3'd2;
    localparam logic [2:0] REG_MAX_RANGE     = 3'd3;
    localparam logic [2:0] REG_USER_CUTOFF   = 3'd4;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd5;

    // Odd Taylor coefficients of sin(pi/2*z) in Q2.30
    localparam logic [31:0] SIN_C9 = 32'd172272;
    localparam logic [31:0] HORNER_COEF [4] = '{
        32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
    };
    localparam int NUM_CELLS = 4;

    // Item travelling down the Horner chain
    typedef struct packed {
        logic        vld;
        logic        tag;   // 0: sine (y), 1: cosine (x)
        logic        neg;
        logic [30:0] z;
        logic [30:0] z2;
        logic [31:0] p;
    } trig_t;

endpackage
`default_nettype wire

@@ hw/rtl/lsp_cell.sv @@
`default_nettype none
module lsp_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [31:0]   coef,
    input  wire lsp_pkg::trig_t cell_i,
    output lsp_pkg::trig_t     cell_o
);
    import lsp_pkg::*;

    logic [62:0] prod;
    trig_t       cell_reg;
    trig_t       cell_next;

    // One Horner step: p = coef - (z2 * p) >> 30
    always_comb begin
        prod      = {32'b0, cell_i.z2} * {31'b0, cell_i.p};
        cell_next = cell_i;
        cell_next.p = coef - prod[61:30];
    end

    // Hand the item to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cell_o = cell_reg;

endmodule
`default_nettype wire

@@ hw/rtl/laser_scan_polar_projection.sv @@
`default_nettype none
// Channel  | Direction | Contents
// s_       | in        | tdata: range_mm[15:0], intensity[31:16]; tlast: scan_last
// m_       | out       | tdata: x_mm, y_mm, sample_index, distance_mm,
//          |           |        point_intensity, stamp_us; tlast: from_last
// cfg_     | in        | cfg_index (register), cfg_data (value), always ready
// A kept sample passes from accept to a loaded result register through the angle,
// reduction, two squaring slots, the four-cell Horner chain, the z*p stage,
// the range scaling stage and the output load. The next sample can be taken in the cycle after the load.
// A dropped sample is discarded at accept and the block stays ready. One sample is in flight at a time.
// A finished result waits in the output register while the next sample is taken;
// if it still waits when the next one is done, the input stalls until it leaves.
// Reset (aresetn low, synchronous) clears the beam counter, configuration and control state.
module laser_scan_polar_projection (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // range_mm[15:0], intensity[31:16]
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // x_mm[16:0], y_mm[33:17], sample_index[45:34],
                                         // distance_mm[61:46], point_intensity[77:62],
                                         // stamp_us[105:78], zero[111:106]
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [16:0]  cfg_data
);
    import lsp_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ANG  = 3'd1;
    localparam logic [2:0] ST_MAG  = 3'd2;
    localparam logic [2:0] ST_SQ0  = 3'd3;
    localparam logic [2:0] ST_SQ1  = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [15:0] start_angle_reg, angle_step_reg, min_range_reg, max_range_reg;
    logic [16:0] user_cutoff_reg;
    logic [15:0] sample_period_reg;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic [15:0] range_reg, inten_reg;
    logic        last_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0] ang_reg;
    logic [27:0] stamp_reg;
    logic [30:0] zs_reg, zc_reg;
    logic        ns_reg, nc_reg;
    logic signed [16:0] x_res_reg, y_res_reg;

    logic [15:0] limit;
    logic        keep;
    logic        s_acc;
    logic        out_free;

    // Configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg   <= '0;
            angle_step_reg    <= '0;
            min_range_reg     <= '0;
            max_range_reg     <= 16'hFFFF;
            user_cutoff_reg   <= 17'h1FFFF;
            sample_period_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_START_ANGLE:   start_angle_reg   <= cfg_data[15:0];
                REG_ANGLE_STEP:    angle_step_reg    <= cfg_data[15:0];
                REG_MIN_RANGE:     min_range_reg     <= cfg_data[15:0];
                REG_MAX_RANGE:     max_range_reg     <= cfg_data[15:0];
                REG_USER_CUTOFF:   user_cutoff_reg   <= cfg_data;
                REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Range gate
    always_comb begin
        if (user_cutoff_reg[16] || user_cutoff_reg[15:0] >= max_range_reg) begin
            limit = max_range_reg;
        end else begin
            limit = user_cutoff_reg[15:0];
        end
        keep = (s_tdata[15:0] >= min_range_reg) && (s_tdata[15:0] <= limit);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    // Beam counter: clear after last sample, saturate at the top index
    always_comb begin
        if (s_tlast) begin
            cnt_next = '0;
        end else if (cnt_reg < MAX_IDX) begin
            cnt_next = cnt_reg + 1'b1;
        end else begin
            cnt_next = MAX_IDX;
        end
    end

    // Sequencer
    logic  f1_vld_reg, f1_tag_reg, f1_neg_reg;
    logic [31:0] f1_q_reg;
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_acc && keep) state_next = ST_ANG;
            ST_ANG:  state_next = ST_MAG;
            ST_MAG:  state_next = ST_SQ0;
            ST_SQ0:  state_next = ST_SQ1;
            ST_SQ1:  state_next = ST_WAIT;
            ST_WAIT: if (f1_vld_reg && f1_tag_reg) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_acc) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Capture the sample
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            range_reg <= s_tdata[15:0];
            inten_reg <= s_tdata[31:16];
            last_reg  <= s_tlast;
            idx_reg   <= cnt_reg;
        end
    end

    // Beam angle and time stamp
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ANG) begin
            ang_reg   <= start_angle_reg + 16'({4'b0, idx_reg} * angle_step_reg);
            stamp_reg <= 28'({16'b0, idx_reg} * {12'b0, sample_period_reg});
        end
    end

    // Fold both angles into a quarter turn
    function automatic logic [30:0] fold_z(input logic [15:0] a);
        logic [14:0] b;
        b = a[14:0];
        if (b > 15'd16384) begin
            b = 15'(16'd32768 - {1'b0, b});
        end
        return {b[14:0], 16'b0};
    endfunction

    logic [15:0] ang_cos;
    assign ang_cos = ang_reg + 16'd16384;
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MAG) begin
            zs_reg <= fold_z(ang_reg);
            ns_reg <= ang_reg[15];
            zc_reg <= fold_z(ang_cos);
            nc_reg <= ang_cos[15];
        end
    end

    // Squaring slot feeds the chain: sine first, cosine next
    logic [30:0] zsel;
    logic [61:0] zsq;
    trig_t       sq_reg;
    assign zsel = (state_reg == ST_SQ1) ? zc_reg : zs_reg;
    assign zsq  = {31'b0, zsel} * {31'b0, zsel};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.vld <= 1'b0;
        end else begin
            sq_reg.vld <= (state_reg == ST_SQ0) || (state_reg == ST_SQ1);
            sq_reg.tag <= (state_reg == ST_SQ1);
            sq_reg.neg <= (state_reg == ST_SQ1) ? nc_reg : ns_reg;
            sq_reg.z   <= zsel;
            sq_reg.z2  <= zsq[60:30];
            sq_reg.p   <= SIN_C9;
        end
    end

    // Horner chain
    trig_t chain [NUM_CELLS+1];
    assign chain[0] = sq_reg;
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        lsp_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .coef    (HORNER_COEF[g]),
            .cell_i  (chain[g]),
            .cell_o  (chain[g+1])
        );
    end

    // Final z * p
    trig_t       ch_out;
    logic [62:0] qprod;
    assign ch_out = chain[NUM_CELLS];
    assign qprod  = {32'b0, ch_out.z} * {31'b0, ch_out.p};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else begin
            f1_vld_reg <= ch_out.vld;
            f1_tag_reg <= ch_out.tag;
            f1_neg_reg <= ch_out.neg;
            f1_q_reg   <= qprod[61:30];
        end
    end

    // Scale by range, round, saturate and sign
    logic [47:0] rprod;
    logic [17:0] mag;
    logic [16:0] coord;
    always_comb begin
        rprod = {32'b0, range_reg} * {16'b0, f1_q_reg};
        rprod = rprod + 48'd536870912;
        mag   = rprod[47:30];
        if (f1_neg_reg) begin
            if (mag > 18'd65536) begin
                mag = 18'd65536;
            end
            coord = 17'(18'h20000 - mag);
        end else begin
            if (mag > 18'd65535) begin
                mag = 18'd65535;
            end
            coord = mag[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_vld_reg) begin
            if (f1_tag_reg) begin
                x_res_reg <= coord;
            end else begin
                y_res_reg <= coord;
            end
        end
    end

    // Output register
    logic m_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_tdata <= {6'b0, stamp_reg, inten_reg, range_reg, idx_reg,
                        y_res_reg, x_res_reg};
            m_tlast <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_IDX) else $error("beam counter above top index");
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tlast |=> cnt_reg == '0) else $error("counter not cleared");
    a_wait_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WAIT && f1_vld_reg && f1_tag_reg |=> state_reg == ST_DONE)
        else $error("cosine result missed");
    a_chain_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !sq_reg.vld) else $error("chain fed while idle");

endmodule
`default_nettype wire
